@@ src/second_order_delta_sigma_modulator_top_macros.svh @@
// Assertion macros used by the modulator RTL
`ifndef SECOND_ORDER_DELTA_SIGMA_MODULATOR_TOP_MACROS_SVH
`define SECOND_ORDER_DELTA_SIGMA_MODULATOR_TOP_MACROS_SVH

// check while out of reset
`define SDM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check at every edge, reset included
`define SDM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/sdm_pkg.sv @@
// Package with constants, types and helpers of the delta-sigma modulator
package sdm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 7;
    localparam int MAX_RATIO = 64;
    localparam int CNT_W    = $clog2(MAX_RATIO);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [RATIO_W-1:0]         ratio_t;
    typedef logic [CNT_W-1:0]           step_cnt_t;

    localparam sample_t FULL_SCALE   = 16'sd32767;
    localparam ratio_t  RATIO_RESET  = 7'd18;
    localparam ratio_t  RATIO_MAX    = 7'd64;

    typedef struct packed {
        logic step_en;
        logic load_en;
    } sdm_ctrl_t;

    function automatic sample_t clamp_sample(input sample_t s);
        sample_t r;
        r = (s < -FULL_SCALE) ? -FULL_SCALE : s;
        return r;
    endfunction

    function automatic step_cnt_t last_index(input ratio_t ratio);
        step_cnt_t r;
        if (ratio == '0) begin
            r = '0;
        end else if (ratio > RATIO_MAX) begin
            r = step_cnt_t'(MAX_RATIO - 1);
        end else begin
            r = step_cnt_t'(ratio - 7'd1);
        end
        return r;
    endfunction

endpackage

@@ src/second_order_delta_sigma_modulator_top.sv @@
// Top level of the second-order one-bit delta-sigma modulator
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_valid / s_ready   | s_sample
//   m_      | out       | m_valid / m_ready   | m_bit_out, m_last_bit
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_data (oversample ratio)
//
// One output beat per cycle while m_ready does not stall; an input sample yields
// max(1, min(ratio, 64)) beats, produced by the single integrator step unit.
// A new sample is taken in the cycle its predecessor's last beat is produced.
// Reset (aresetn low, synchronous) clears integrators, ratio to 18, all valids.
// A stall on m_ready holds the output register and the step counter.
`include "second_order_delta_sigma_modulator_top_macros.svh"

module second_order_delta_sigma_modulator_top
    import sdm_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [15:0]   s_sample,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_bit_out,
    output logic          m_last_bit,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    cfg_data
);

    ratio_t    ratio_reg;
    logic      busy_reg;
    sample_t   sample_reg;
    step_cnt_t count_reg;
    logic      m_valid_reg;
    logic      m_bit_reg;
    logic      m_last_reg;
    step_cnt_t last_idx;
    logic      step_last;
    logic      in_fire;
    logic      bit_next;
    sdm_ctrl_t ctrl;

    assign last_idx     = last_index(ratio_reg);
    assign step_last    = (count_reg == last_idx);
    assign ctrl.step_en = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready      = !busy_reg || (ctrl.step_en && step_last);
    assign in_fire      = s_valid && s_ready;
    assign ctrl.load_en = in_fire;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RESET;
        end else if (cfg_valid && cfg_ready) begin
            ratio_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (ctrl.load_en) begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end else if (ctrl.step_en) begin
            busy_reg  <= !step_last;
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_en) begin
            sample_reg <= clamp_sample(sample_t'(s_sample));
        end
    end

    sdm_integ #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_integ (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample_in (sample_reg),
        .bit_next  (bit_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step_en) begin
            m_bit_reg  <= bit_next;
            m_last_reg <= step_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_bit_out  = m_bit_reg;
    assign m_last_bit = m_last_reg;

    `SDM_ASSERT(a_load_only_at_end, in_fire && busy_reg |-> ctrl.step_en && step_last, "sample taken mid-burst")
    `SDM_ASSERT(a_idle_after_last, ctrl.step_en && step_last && !in_fire |=> !busy_reg, "busy held past last beat")
    `SDM_ASSERT(a_count_in_range, busy_reg |-> count_reg <= last_idx, "step count beyond ratio")
    `SDM_ASSERT(a_last_flag, ctrl.step_en |=> m_last_bit == $past(step_last), "last flag mismatch")
    `SDM_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid && !busy_reg, "reset left a beat pending")

endmodule

@@ src/sdm_integ.sv @@
// Two cascaded integrators with one-bit quantizer feedback
module sdm_integ
    import sdm_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  sdm_ctrl_t ctrl,
    input  sample_t   sample_in,
    output logic      bit_next
);

    localparam logic [ACC_WIDTH-1:0] FB_POS =
        {{(ACC_WIDTH-SAMPLE_W){FULL_SCALE[SAMPLE_W-1]}}, FULL_SCALE};
    localparam logic [ACC_WIDTH-1:0] FB_NEG = ~FB_POS + 1'b1;

    logic [ACC_WIDTH-1:0] int1_reg, int1_next;
    logic [ACC_WIDTH-1:0] int2_reg, int2_next;
    logic [ACC_WIDTH-1:0] sample_ext;
    logic [ACC_WIDTH-1:0] fb;
    logic                 int2_pos;

    assign sample_ext = {{(ACC_WIDTH-SAMPLE_W){sample_in[SAMPLE_W-1]}}, sample_in};
    assign int2_pos   = (int2_reg != '0) && !int2_reg[ACC_WIDTH-1];
    assign fb         = int2_pos ? FB_POS : FB_NEG;

    always_comb begin
        int1_next = int1_reg + sample_ext - fb;
        int2_next = int2_reg + int1_next - fb;
    end

    assign bit_next = (int2_next != '0) && !int2_next[ACC_WIDTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int1_reg <= '0;
            int2_reg <= '0;
        end else if (ctrl.step_en) begin
            int1_reg <= int1_next;
            int2_reg <= int2_next;
        end
    end

endmodule
